// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the u8u16 RTL files.
// Clocked on the rising edge, disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

// ===== hdl/u8u16_pkg.sv =====
// Types, constants and byte helpers for the UTF-8 to UTF-16 decoder.
// No dependencies; used by every module of the block.
package u8u16_pkg;

    localparam logic [15:0] UNIT_REPL    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam int          MAX_UNITS    = 3;

    typedef logic [20:0] t_cp;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
    } t_out_beat;

    // All units one input byte produces, unit 0 first.
    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_UNITS-1:0][15:0]  units;
    } t_pkt;

    // Sequence length announced by a lead byte.
    function automatic logic [2:0] lead_width(input logic [7:0] c);
        logic [2:0] w;
        if (!c[7]) begin
            w = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            w = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            w = 3'd3;
        end else begin
            w = 3'd4;
        end
        return w;
    endfunction

    // Payload bits of a lead byte.
    function automatic logic [6:0] lead_bits(input logic [7:0] c);
        logic [6:0] b;
        case (lead_width(c))
            3'd1:    b = c[6:0];
            3'd2:    b = {2'b00, c[4:0]};
            3'd3:    b = {3'b000, c[3:0]};
            default: b = {4'b0000, c[2:0]};
        endcase
        return b;
    endfunction

    // A lone byte at the end of a stream: ASCII, or a replacement unit.
    function automatic logic [15:0] lone_unit(input logic [7:0] c);
        return c[7] ? UNIT_REPL : {8'h00, c};
    endfunction

endpackage

// ===== hdl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder: one input byte per beat, UTF-16 code units out.
// An accepted byte waits in the input register until the drain frees, then its decoded units load
// the packet register, which offers the first. One byte per cycle while each byte yields at most
// one unit and the receiver is ready; extra units (surrogate pair, truncated tail) stall the input.
// Reset (synchronous, i_rst_n low) closes any open sequence and empties both registers;
// buffered sequence bytes are not cleared and are only read after being written.
module utf8_to_utf16_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  u8u16_pkg::t_in_beat   i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output u8u16_pkg::t_out_beat  o_out_beat
);
    import u8u16_pkg::*;

    // Input register: holds one accepted beat until the packet register frees up.
    t_in_beat r_in;
    logic     r_in_valid;

    logic     pkt_free;
    logic     advance;
    t_pkt     pkt;

    // Advance the held beat into decode when the drain can take its packet.
    assign advance    = r_in_valid && pkt_free;
    // Accept a new beat while the input register is empty or draining this cycle.
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_beat;
        end
    end

    // Decode: sequence state update and the units for this byte.
    u8u16_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_beat  (r_in),
        .o_pkt   (pkt)
    );

    // Drain: hold the packet and hand out one unit per beat.
    u8u16_drain u_drain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_pkt   (pkt),
        .o_free  (pkt_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

endmodule

// ===== hdl/u8u16_step.sv =====
// Sequence state and per-byte decode for the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  u8u16_pkg::t_in_beat   i_beat,
    output u8u16_pkg::t_pkt       o_pkt
);
    import u8u16_pkg::*;

    logic [7:0] r_pend [3];
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_len, n_len;
    logic       pend_we;
    logic [1:0] pend_idx;

    logic [7:0]  b;
    logic        eos;
    logic        seq_open;
    logic        complete;
    logic [6:0]  lb;
    t_cp         cp;
    t_cp         cp_off;
    logic [15:0] cp_hi, cp_lo;
    logic        cp_pair;

    always_comb begin
        b        = i_beat.in_byte;
        eos      = i_beat.end_of_stream;
        seq_open = (r_len != 3'd0);
        complete = seq_open && ((({1'b0, r_cnt} + 3'd1) >= r_len) || (r_cnt == 2'd3));
        lb       = lead_bits(r_pend[0]);

        // Assemble the full code point from the lead, buffered continuations and b.
        case (r_cnt)
            2'd1:    cp = t_cp'({lb, b[5:0]});
            2'd2:    cp = t_cp'({lb, r_pend[1][5:0], b[5:0]});
            2'd3:    cp = {lb[2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
            default: cp = '0;
        endcase
        cp_pair = (cp > t_cp'(16'hFFFF));
        cp_off  = cp - SUPP_BASE;
        cp_hi   = SURR_HI_BASE + {5'b00000, cp_off[20:10]};
        cp_lo   = SURR_LO_BASE + {6'b000000, cp_off[9:0]};
    end

    always_comb begin
        o_pkt    = '0;
        n_cnt    = r_cnt;
        n_len    = r_len;
        pend_we  = 1'b0;
        pend_idx = r_cnt;
        if (!seq_open) begin
            if (eos) begin
                o_pkt.count    = 2'd1;
                o_pkt.units[0] = lone_unit(b);
            end else if (!b[7]) begin
                o_pkt.count    = 2'd1;
                o_pkt.units[0] = {8'h00, b};
            end else begin
                // Open a sequence: buffer the lead.
                pend_we  = 1'b1;
                pend_idx = 2'd0;
                n_cnt    = 2'd1;
                n_len    = lead_width(b);
            end
        end else if (complete) begin
            if (cp_pair) begin
                o_pkt.count    = 2'd2;
                o_pkt.units[0] = cp_hi;
                o_pkt.units[1] = cp_lo;
            end else begin
                o_pkt.count    = 2'd1;
                o_pkt.units[0] = cp[15:0];
            end
            n_cnt = 2'd0;
            n_len = 3'd0;
        end else if (!eos) begin
            pend_we = 1'b1;
            n_cnt   = r_cnt + 2'd1;
        end else begin
            // Truncated: replace the lead, re-decode the rest as fresh leads.
            o_pkt.units[0] = UNIT_REPL;
            if (r_cnt == 2'd1) begin
                o_pkt.count    = 2'd2;
                o_pkt.units[1] = lone_unit(b);
            end else begin
                case (lead_width(r_pend[1]))
                    3'd1: begin
                        o_pkt.count    = 2'd3;
                        o_pkt.units[1] = {8'h00, r_pend[1]};
                        o_pkt.units[2] = lone_unit(b);
                    end
                    3'd2: begin
                        o_pkt.count    = 2'd2;
                        o_pkt.units[1] = {5'b00000, r_pend[1][4:0], b[5:0]};
                    end
                    default: begin
                        o_pkt.count    = 2'd3;
                        o_pkt.units[1] = UNIT_REPL;
                        o_pkt.units[2] = lone_unit(b);
                    end
                endcase
            end
            n_cnt = 2'd0;
            n_len = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_len <= 3'd0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && pend_we && (pend_idx != 2'd3)) begin
            r_pend[pend_idx] <= b;
        end
    end

    `ASSERT_NOW(a_open_has_lead, i_clk, i_rst_n, r_len != 3'd0, (r_cnt != 2'd0) && ({1'b0, r_cnt} < r_len))
    `ASSERT_NOW(a_closed_empty, i_clk, i_rst_n, r_len == 3'd0, r_cnt == 2'd0)

endmodule

// ===== hdl/u8u16_drain.sv =====
// Result packet register and output drain, one unit per cycle while the receiver is ready.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_drain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  u8u16_pkg::t_pkt       i_pkt,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output u8u16_pkg::t_out_beat  o_beat
);
    import u8u16_pkg::*;

    t_pkt       r_pkt;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last;
    logic       take;

    assign last    = ((r_idx + 2'd1) == r_pkt.count);
    assign take    = r_valid && i_ready;
    assign o_free  = !r_valid || (take && last);
    assign o_valid = r_valid;
    assign o_beat.code_unit = r_pkt.units[r_idx];
    assign o_beat.run_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_free) begin
            // Take a new packet as valid only if it carries units.
            r_valid <= i_load && (i_pkt.count != 2'd0);
            r_idx   <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_pkt <= i_pkt;
        end
    end

    `ASSERT_NOW(a_idx_in_pkt, i_clk, i_rst_n, r_valid, r_idx < r_pkt.count)
    `ASSERT_NEXT(a_idx_advance, i_clk, i_rst_n, take && !last, r_valid && (r_idx == $past(r_idx) + 2'd1))

endmodule

// ===== verif/utf8_to_utf16_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_decoder: UTF-8 byte beats in, UTF-16 unit beats out.
// Needs u8u16_pkg and the decoder RTL; stimulus is directed strings, then random runs.
module utf8_to_utf16_decoder_tb;
    import u8u16_pkg::*;

    localparam int RANDOM_BYTES = 285;
    localparam int IDLE_LIMIT   = 1000;  // cycles without any accepted beat
    localparam int DRAIN_CYCLES = 20;    // quiet time after the last expected unit
    localparam int LONG_HOLD    = 150;   // receiver back-pressure stretch
    localparam int HOLD_AT_UNIT = 60;    // unit count that triggers the stretch
    localparam logic [31:0] TEN_BITS = 32'h3FF;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    utf8_to_utf16_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (o_out_beat)
    );

    // Byte beats waiting to be driven, and UTF-16 units still owed by the block.
    t_in_beat    byte_q[$];
    t_out_beat   units_q[$];
    logic [15:0] unit_buf[$];

    // Shadow of the decoder's open-sequence state.
    logic [7:0]  seq_buf[3];
    logic [1:0]  seq_cnt = '0;
    logic [2:0]  seq_len = '0;

    int n_total     = 0;
    int n_bytes     = 0;
    int n_ends      = 0;
    int n_units     = 0;
    int n_repl      = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int tx_wait     = 0;
    int rx_wait     = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hold reset low from the start, then release it for good.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------

    // Sequence length that a lead byte announces; anything unrecognized counts as four.
    function automatic int utf8_len(input logic [7:0] b);
        if (b[7] == 1'b0)         return 1;
        if (b[7:5] == 3'b110)     return 2;
        if (b[7:4] == 4'b1110)    return 3;
        return 4;
    endfunction

    function automatic logic [31:0] lead_payload(input logic [7:0] b);
        case (utf8_len(b))
            1:       return {24'd0, b};
            2:       return {27'd0, b[4:0]};
            3:       return {28'd0, b[3:0]};
            default: return {29'd0, b[2:0]};
        endcase
    endfunction

    // Append one code point as a single unit or as a surrogate pair.
    function automatic void add_point(input logic [31:0] cp);
        logic [31:0] v;
        if (cp > 32'h0000_FFFF) begin
            v = cp - 32'(SUPP_BASE);
            unit_buf.push_back(SURR_HI_BASE + 16'(v >> 10));
            unit_buf.push_back(SURR_LO_BASE + 16'(v & TEN_BITS));
        end else begin
            unit_buf.push_back(cp[15:0]);
        end
    endfunction

    // Advance the shadow state by one accepted byte and queue the units it releases.
    function automatic void decode_byte(input t_in_beat ib);
        logic [7:0]  b;
        logic [7:0]  tail[4];
        logic [31:0] cp;
        t_out_beat   ob;
        int          cnt, m, i, w, k, n;
        b   = ib.in_byte;
        cnt = seq_cnt;
        unit_buf.delete();
        if (!ib.end_of_stream) begin
            if (seq_len == 3'd0) begin
                if (utf8_len(b) == 1) begin
                    add_point({24'd0, b});
                end else begin
                    seq_buf[0] = b;
                    seq_cnt    = 2'd1;
                    seq_len    = 3'(utf8_len(b));
                end
            end else if (cnt + 1 >= seq_len || cnt >= 3) begin
                cp = lead_payload(seq_buf[0]);
                for (k = 1; k < cnt; k++) cp = (cp << 6) | seq_buf[k][5:0];
                cp = (cp << 6) | b[5:0];
                add_point(cp);
                seq_cnt = '0;
                seq_len = '0;
            end else begin
                seq_buf[cnt] = b;
                seq_cnt      = 2'(cnt + 1);
            end
        end else begin
            // End of stream: decode pending bytes plus this one from the start,
            // replacing any lead whose sequence does not fit and moving on one byte.
            m = 0;
            if (seq_len != 3'd0) begin
                for (k = 0; k < cnt; k++) begin
                    tail[m] = seq_buf[k];
                    m++;
                end
            end
            tail[m] = b;
            m++;
            i = 0;
            while (i < m) begin
                w = utf8_len(tail[i]);
                if (i + w > m) begin
                    cp = {16'd0, UNIT_REPL};
                    w  = 1;
                end else begin
                    cp = lead_payload(tail[i]);
                    for (k = 1; k < w; k++) cp = (cp << 6) | tail[i + k][5:0];
                end
                i += w;
                add_point(cp);
            end
            seq_cnt = '0;
            seq_len = '0;
        end
        n = (unit_buf.size() > MAX_UNITS) ? MAX_UNITS : unit_buf.size();
        for (k = 0; k < n; k++) begin
            ob.code_unit = unit_buf[k];
            ob.run_last  = (k + 1 == n);
            units_q.push_back(ob);
        end
    endfunction

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------

    task automatic put(input logic [7:0] b, input bit eos);
        t_in_beat ib;
        ib.in_byte       = b;
        ib.end_of_stream = eos;
        byte_q.push_back(ib);
    endtask

    // One run of mostly well-formed characters with random payload bits. Some runs
    // cut their last character short, some carry noise bytes, and a few do not
    // close the stream so the next run can land inside an open sequence.
    task automatic add_run();
        logic [7:0] run_bytes[$];
        int         nchars, len, c, k;
        bit         broken, closed;
        nchars = $urandom_range(1, 6);
        broken = ($urandom_range(0, 2) == 0);
        closed = ($urandom_range(0, 5) != 0);
        for (c = 0; c < nchars; c++) begin
            if ($urandom_range(0, 9) == 0) begin
                run_bytes.push_back(8'($urandom));
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       run_bytes.push_back({1'b0, 7'($urandom)});
                    2:       run_bytes.push_back({3'b110, 5'($urandom)});
                    3:       run_bytes.push_back({4'b1110, 4'($urandom)});
                    default: begin
                        if ($urandom_range(0, 5) == 0) begin
                            run_bytes.push_back({2'b10, 6'($urandom)});
                        end else begin
                            run_bytes.push_back({4'b1111, 4'($urandom)});
                        end
                    end
                endcase
                for (k = 1; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        run_bytes.push_back(8'($urandom));
                    end else begin
                        run_bytes.push_back({2'b10, 6'($urandom)});
                    end
                end
                if (broken && c == nchars - 1 && len > 1) begin
                    repeat ($urandom_range(1, len - 1)) void'(run_bytes.pop_back());
                end
            end
        end
        for (k = 0; k < run_bytes.size(); k++) begin
            put(run_bytes[k], closed && (k == run_bytes.size() - 1));
        end
    endtask

    initial begin : stimulus
        int n_directed;
        // Directed strings: ASCII extremes, two-byte and four-byte characters,
        // a pair closed by end of stream, a surrogate code point passed through,
        // the largest reachable code point, lone and truncated leads at the end,
        // and stray continuations that expand into three replacement units.
        put(8'h00, 1'b0);
        put(8'h7F, 1'b0);
        put(8'hC2, 1'b0); put(8'hA9, 1'b0);
        put(8'hF0, 1'b0); put(8'h9F, 1'b0); put(8'h98, 1'b0); put(8'h80, 1'b1);
        put(8'hED, 1'b0); put(8'hA0, 1'b0); put(8'h80, 1'b0);
        put(8'hF7, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0);
        put(8'hFF, 1'b1);
        put(8'hF0, 1'b0); put(8'h80, 1'b0); put(8'h41, 1'b1);
        put(8'hE0, 1'b0); put(8'hC3, 1'b1);
        put(8'h41, 1'b1);
        put(8'h80, 1'b0); put(8'h80, 1'b0); put(8'h80, 1'b1);
        n_directed = byte_q.size();
        while (byte_q.size() < n_directed + RANDOM_BYTES) add_run();
        n_total = byte_q.size();

        // Wait for every byte to go in and every owed unit to come out,
        // then give the block time to show any unit it should not send.
        while (n_bytes < n_total) @(posedge i_clk);
        while (units_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes sent (%0d stream ends), %0d code units checked, %0d replacements",
                 n_bytes, n_ends, n_units, n_repl);
        if (mismatches == 0 && units_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    //------------------------------------------------------------------
    // Driver: offer byte beats with random gaps, predict on acceptance.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        bit take;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            take = !in_valid;
            if (in_valid && o_in_ready) begin
                decode_byte(in_beat);
                n_bytes++;
                if (in_beat.end_of_stream) n_ends++;
                take = 1'b1;
            end
            // Flip between bursty and back-to-back phases now and then.
            if ($urandom_range(0, 29) == 0) tx_quiet <= ~tx_quiet;
            if (take && tx_wait > 0) begin
                tx_wait  <= tx_wait - 1;
                in_valid <= 1'b0;
            end else if (take && byte_q.size() > 0) begin
                in_valid <= 1'b1;
                in_beat  <= byte_q.pop_front();
                tx_wait  <= tx_quiet ? 0 : $urandom_range(0, 9);
            end else if (take) begin
                in_valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor: check each accepted unit against the oldest prediction,
    // and pace ready with random stalls plus one long hold-off.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin : unit_monitor
        t_out_beat want;
        int        wait_n;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else begin
            wait_n = rx_wait;
            if (o_out_valid && out_ready) begin
                n_units++;
                if (o_out_beat.code_unit == UNIT_REPL) n_repl++;
                if (units_q.size() == 0) begin
                    $error("unexpected unit: code_unit %h run_last %b",
                           o_out_beat.code_unit, o_out_beat.run_last);
                    mismatches++;
                end else begin
                    want = units_q.pop_front();
                    if (o_out_beat.code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h",
                               want.code_unit, o_out_beat.code_unit);
                        mismatches++;
                    end
                    if (o_out_beat.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b",
                               want.run_last, o_out_beat.run_last);
                        mismatches++;
                    end
                end
                wait_n = rx_quiet ? 0 : $urandom_range(0, 9);
                // Stall long enough that the block fills and holds off the sender.
                if (n_units == HOLD_AT_UNIT) wait_n = LONG_HOLD;
            end
            if ($urandom_range(0, 29) == 0) rx_quiet <= ~rx_quiet;
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                rx_wait   <= wait_n - 1;
            end else begin
                out_ready <= 1'b1;
                rx_wait   <= 0;
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog: end the run when no beat moves on either side for too long.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: %0d of %0d bytes sent, %0d units outstanding",
                 n_bytes, n_total, units_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/u8u16_pkg.sv
hdl/u8u16_step.sv
hdl/u8u16_drain.sv
hdl/utf8_to_utf16_decoder.sv
verif/utf8_to_utf16_decoder_tb.sv
